@@ sv/pm0_pkg.sv @@
// Package for the P-machine execution block: opcodes, sub-operation codes,
// status codes, the queue entry type shared by the front and back, and the divider request type.
// Depends on nothing.
package pm0_pkg;

	localparam logic [3:0] OP_LIT = 4'd1;
	localparam logic [3:0] OP_OPR = 4'd2;
	localparam logic [3:0] OP_LOD = 4'd3;
	localparam logic [3:0] OP_STO = 4'd4;
	localparam logic [3:0] OP_CAL = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_JMP = 4'd7;
	localparam logic [3:0] OP_JPC = 4'd8;
	localparam logic [3:0] OP_SIO = 4'd9;

	localparam logic [3:0] OPR_RET = 4'd0;
	localparam logic [3:0] OPR_NEG = 4'd1;
	localparam logic [3:0] OPR_ADD = 4'd2;
	localparam logic [3:0] OPR_SUB = 4'd3;
	localparam logic [3:0] OPR_MUL = 4'd4;
	localparam logic [3:0] OPR_DIV = 4'd5;
	localparam logic [3:0] OPR_ODD = 4'd6;
	localparam logic [3:0] OPR_MOD = 4'd7;
	localparam logic [3:0] OPR_EQL = 4'd8;
	localparam logic [3:0] OPR_NEQ = 4'd9;
	localparam logic [3:0] OPR_LSS = 4'd10;
	localparam logic [3:0] OPR_LEQ = 4'd11;
	localparam logic [3:0] OPR_GTR = 4'd12;
	localparam logic [3:0] OPR_GEQ = 4'd13;

	localparam logic signed [31:0] SIO_PRINT = 32'sd0;
	localparam logic signed [31:0] SIO_READ  = 32'sd1;
	localparam logic signed [31:0] SIO_HALT  = 32'sd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INV   = 2'd1;
	localparam logic [1:0] ST_DIVZ  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] MD_MUL = 2'd0;
	localparam logic [1:0] MD_DIV = 2'd1;
	localparam logic [1:0] MD_MOD = 2'd2;

	typedef struct packed {
		logic [3:0]         op;
		logic [1:0]         level;
		logic signed [31:0] m;
		logic signed [31:0] iv;
		logic               bad;
		logic               tgt_ok;
	} entry_t;

	typedef struct packed {
		logic       start;
		logic [1:0] kind;
	} md_req_t;

endpackage

@@ sv/pm0_if.sv @@
// Handshake interfaces for the instruction channel and the result channel.
// Depends on nothing.
interface pm0_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         op;
	logic [1:0]         level;
	logic signed [31:0] m_field;
	logic signed [31:0] in_value;
	modport source (output valid, op, level, m_field, in_value, input ready);
	modport sink (input valid, op, level, m_field, in_value, output ready);
endinterface

interface pm0_out_if;
	logic               valid;
	logic               ready;
	logic [8:0]         next_pc;
	logic [10:0]        sp_after;
	logic [10:0]        bp_after;
	logic signed [31:0] top_value;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic               halted;
	logic [1:0]         status;
	modport source (output valid, next_pc, sp_after, bp_after, top_value, print_valid,
		print_value, halted, status, input ready);
	modport sink (input valid, next_pc, sp_after, bp_after, top_value, print_valid,
		print_value, halted, status, output ready);
endinterface

@@ sv/pm0_front.sv @@
// Front end: accepts instruction items, checks opcode, sub-operation, level and
// jump target, and holds them in a two-entry queue. Depends on pm0_pkg, pm0_if.
module pm0_front #(
	parameter int CODE_DEPTH = 512,
	parameter int MAX_LEVELS = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	pm0_in_if.sink          in_ch,
	input  logic            clearing,
	input  logic            pop,
	output logic            head_valid,
	output pm0_pkg::entry_t head
);
	import pm0_pkg::*;

	localparam logic [4:0] MaxL = 5'(MAX_LEVELS);
	localparam logic signed [31:0] CodeD = 32'(CODE_DEPTH);

	entry_t     q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	entry_t     cls;
	logic       push;
	logic       tgt_ok;
	logic       lvl_bad;
	logic       sub_bad;

	always_comb begin
		tgt_ok  = (in_ch.m_field >= 32'sd0) && (in_ch.m_field < CodeD);
		lvl_bad = {3'b000, in_ch.level} > MaxL;
		sub_bad = 1'b0;
		case (in_ch.op)
			OP_LIT, OP_INC, OP_JPC: sub_bad = 1'b0;
			OP_OPR: sub_bad = (in_ch.m_field < 32'sd0) || (in_ch.m_field > 32'sd13);
			OP_LOD, OP_STO: sub_bad = lvl_bad;
			OP_CAL: sub_bad = lvl_bad || !tgt_ok;
			OP_JMP: sub_bad = !tgt_ok;
			OP_SIO: sub_bad = (in_ch.m_field < SIO_PRINT) || (in_ch.m_field > SIO_HALT);
			default: sub_bad = 1'b1;
		endcase
		cls.op     = in_ch.op;
		cls.level  = in_ch.level;
		cls.m      = in_ch.m_field;
		cls.iv     = in_ch.in_value;
		cls.bad    = sub_bad;
		cls.tgt_ok = tgt_ok;
	end

	assign in_ch.ready = !clearing && (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = cnt_q != 2'd0;
	assign head        = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ sv/pm0_muldiv.sv @@
// Iterative multiplier and divider, one bit per cycle, used for OPR multiply,
// divide and modulo. Depends on pm0_pkg.
module pm0_muldiv #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pm0_pkg::md_req_t     req,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);
	import pm0_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    kind_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W-1:0]  rem_q;
	logic          negq_q;
	logic          negr_q;
	logic [W:0]    trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, x_q[W-1]};
		fits  = trial >= {1'b0, y_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			kind_q <= MD_MUL;
			acc_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			rem_q  <= '0;
			negq_q <= 1'b0;
			negr_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
				kind_q <= req.kind;
				acc_q  <= '0;
				rem_q  <= '0;
				negq_q <= a[W-1] ^ b[W-1];
				negr_q <= a[W-1];
				if (req.kind == MD_MUL) begin
					x_q <= a;
					y_q <= b;
				end else begin
					x_q <= a[W-1] ? -a : a;
					y_q <= b[W-1] ? -b : b;
				end
			end else if (busy_q) begin
				if (kind_q == MD_MUL) begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= {x_q[W-2:0], 1'b0};
					y_q <= {1'b0, y_q[W-1:1]};
				end else begin
					rem_q <= fits ? W'(trial - {1'b0, y_q}) : trial[W-1:0];
					x_q   <= {x_q[W-2:0], fits};
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (kind_q)
			MD_MUL: result = acc_q;
			MD_DIV: result = negq_q ? -x_q : x_q;
			default: result = negr_q ? -rem_q : rem_q;
		endcase
	end

	assign done = done_q;
endmodule

@@ sv/pm0_back.sv @@
// Back end: sequencer that carries out one queued instruction at a time on the
// stack memory and registers the result item. Depends on pm0_pkg, pm0_if, pm0_muldiv.
module pm0_back #(
	parameter int STACK_DEPTH = 2048,
	parameter int CODE_DEPTH  = 512,
	parameter int WORD_BITS   = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  pm0_pkg::entry_t head,
	output logic            pop,
	output logic            clearing,
	pm0_out_if.source       out_ch
);
	import pm0_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int PC_W = $clog2(CODE_DEPTH);
	localparam int BW   = ((W > 32) ? W : 32) + 2;
	localparam logic signed [BW-1:0] DepB  = BW'(STACK_DEPTH);
	localparam logic signed [BW-1:0] CodeB = BW'(CODE_DEPTH);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_EXEC  = 5'd2;
	localparam logic [4:0] S_PRT   = 5'd3;
	localparam logic [4:0] S_JPC   = 5'd4;
	localparam logic [4:0] S_WALK  = 5'd5;
	localparam logic [4:0] S_WALKD = 5'd6;
	localparam logic [4:0] S_ADDR  = 5'd7;
	localparam logic [4:0] S_LODW  = 5'd8;
	localparam logic [4:0] S_STOW  = 5'd9;
	localparam logic [4:0] S_CALW  = 5'd10;
	localparam logic [4:0] S_RET1  = 5'd11;
	localparam logic [4:0] S_RET2  = 5'd12;
	localparam logic [4:0] S_UNA   = 5'd13;
	localparam logic [4:0] S_BIN1  = 5'd14;
	localparam logic [4:0] S_BIN2  = 5'd15;
	localparam logic [4:0] S_MD    = 5'd16;
	localparam logic [4:0] S_TOP   = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;

	logic [W-1:0]    mem [STACK_DEPTH];
	logic [W-1:0]    rdata_q;
	logic [SP_W-1:0] raddr_c;
	logic            we_c;
	logic [SP_W-1:0] waddr_c;
	logic [W-1:0]    wdata_c;

	logic [4:0]      state_q;
	logic [SP_W-1:0] clr_q;
	logic [PC_W-1:0] pc_q;
	logic [SP_W-1:0] sp_q;
	logic [SP_W-1:0] bp_q;
	logic            halt_q;
	entry_t          cur_q;
	logic [1:0]      st_q;
	logic            pv_q;
	logic [W-1:0]    pval_q;
	logic [SP_W-1:0] base_q;
	logic [1:0]      cnt_q;
	logic [SP_W-1:0] addr_q;
	logic [W-1:0]    b_q;
	logic [W-1:0]    ra_q;

	logic            out_valid_q;
	logic [8:0]      o_pc_q;
	logic [10:0]     o_sp_q;
	logic [10:0]     o_bp_q;
	logic [31:0]     o_top_q;
	logic            o_pv_q;
	logic [31:0]     o_pval_q;
	logic            o_halt_q;
	logic [1:0]      o_st_q;

	logic signed [BW-1:0] sp_b, bp_b, base_b, m_b, inc_b, addr_b, rd_b, ra_b;
	logic            sp1_ok, sp4_ok, sp_nz, inc_ok, addr_ok, ret_ok, base1_ok, rd_ok, ra_ok;
	logic [PC_W-1:0] npc;
	logic [3:0]      mop;
	logic            is_md;
	logic            divz;
	logic [W-1:0]    alu;
	logic signed [W-1:0] sa, sb;
	md_req_t         md_req;
	logic            md_done;
	logic [W-1:0]    md_res;

	function automatic logic in_stk(input logic signed [BW-1:0] x);
		return (x >= 0) && (x < DepB);
	endfunction

	always_comb begin
		sp_b     = signed'(BW'(sp_q));
		bp_b     = signed'(BW'(bp_q));
		base_b   = signed'(BW'(base_q));
		m_b      = BW'(cur_q.m);
		inc_b    = sp_b + m_b;
		addr_b   = base_b + m_b;
		rd_b     = BW'(signed'(rdata_q));
		ra_b     = BW'(signed'(ra_q));
		sp1_ok   = (sp_b + 1) < DepB;
		sp4_ok   = (sp_b + 4) < DepB;
		sp_nz    = sp_q != '0;
		inc_ok   = in_stk(inc_b);
		addr_ok  = in_stk(addr_b);
		ret_ok   = (bp_q != '0) && ((bp_b + 3) < DepB);
		base1_ok = (base_b + 1) < DepB;
		rd_ok    = in_stk(rd_b);
		ra_ok    = (ra_b >= 0) && (ra_b < CodeB);
		npc      = (pc_q == PC_W'(CODE_DEPTH - 1)) ? '0 : pc_q + PC_W'(1);
		mop      = cur_q.m[3:0];
		is_md    = (mop == OPR_MUL) || (mop == OPR_DIV) || (mop == OPR_MOD);
		sa       = signed'(rdata_q);
		sb       = signed'(b_q);
		divz     = ((mop == OPR_DIV) || (mop == OPR_MOD)) && (b_q == '0);
		case (mop)
			OPR_ADD: alu = rdata_q + b_q;
			OPR_SUB: alu = rdata_q - b_q;
			OPR_EQL: alu = W'(sa == sb);
			OPR_NEQ: alu = W'(sa != sb);
			OPR_LSS: alu = W'(sa < sb);
			OPR_LEQ: alu = W'(sa <= sb);
			OPR_GTR: alu = W'(sa > sb);
			default: alu = W'(sa >= sb);
		endcase
	end

	// Memory port control, one write and one read address per cycle.
	always_comb begin
		raddr_c = sp_q;
		we_c    = 1'b0;
		waddr_c = sp_q + SP_W'(1);
		wdata_c = '0;
		md_req.start = 1'b0;
		md_req.kind  = (mop == OPR_MUL) ? MD_MUL : ((mop == OPR_DIV) ? MD_DIV : MD_MOD);
		case (state_q)
			S_CLR: begin
				we_c    = 1'b1;
				waddr_c = clr_q;
			end
			S_EXEC: begin
				if (cur_q.op == OP_OPR && mop == OPR_RET) begin
					raddr_c = bp_q + SP_W'(3);
				end
				if (!halt_q && !cur_q.bad && sp1_ok &&
					(cur_q.op == OP_LIT || (cur_q.op == OP_SIO && cur_q.m == SIO_READ))) begin
					we_c    = 1'b1;
					wdata_c = (cur_q.op == OP_LIT) ? W'(cur_q.m) : W'(cur_q.iv);
				end
			end
			S_WALK: raddr_c = base_q + SP_W'(1);
			S_ADDR: raddr_c = (cur_q.op == OP_LOD) ? addr_b[SP_W-1:0] : sp_q;
			S_LODW: begin
				we_c    = 1'b1;
				wdata_c = rdata_q;
			end
			S_STOW: begin
				we_c    = 1'b1;
				waddr_c = addr_q;
				wdata_c = rdata_q;
			end
			S_CALW: begin
				we_c    = 1'b1;
				waddr_c = sp_q + SP_W'(1) + SP_W'(cnt_q);
				case (cnt_q)
					2'd0: wdata_c = '0;
					2'd1: wdata_c = W'(base_q);
					2'd2: wdata_c = W'(bp_q);
					default: wdata_c = W'(pc_q);
				endcase
			end
			S_RET1: raddr_c = bp_q + SP_W'(2);
			S_UNA: begin
				we_c    = 1'b1;
				waddr_c = sp_q;
				wdata_c = (mop == OPR_NEG) ? -rdata_q : (rdata_q & W'(1));
			end
			S_BIN1: raddr_c = sp_q - SP_W'(1);
			S_BIN2: begin
				waddr_c = sp_q - SP_W'(1);
				wdata_c = alu;
				we_c    = !divz && !is_md;
				md_req.start = !divz && is_md;
			end
			S_MD: begin
				waddr_c = sp_q - SP_W'(1);
				wdata_c = md_res;
				we_c    = md_done;
			end
			default: raddr_c = sp_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		rdata_q <= mem[raddr_c];
	end

	pm0_muldiv #(.WORD_BITS(W)) u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (rdata_q),
		.b      (b_q),
		.done   (md_done),
		.result (md_res)
	);

	assign pop      = (state_q == S_IDLE) && head_valid && !out_valid_q;
	assign clearing = state_q == S_CLR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			pc_q        <= '0;
			sp_q        <= '0;
			bp_q        <= SP_W'(1);
			halt_q      <= 1'b0;
			cur_q       <= '0;
			st_q        <= ST_OK;
			pv_q        <= 1'b0;
			pval_q      <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			addr_q      <= '0;
			b_q         <= '0;
			ra_q        <= '0;
			out_valid_q <= 1'b0;
			o_pc_q      <= '0;
			o_sp_q      <= '0;
			o_bp_q      <= '0;
			o_top_q     <= '0;
			o_pv_q      <= 1'b0;
			o_pval_q    <= '0;
			o_halt_q    <= 1'b0;
			o_st_q      <= ST_OK;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SP_W'(1);
					if (clr_q == SP_W'(STACK_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						cur_q   <= head;
						st_q    <= ST_OK;
						pv_q    <= 1'b0;
						pval_q  <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_TOP;
					if (!halt_q) begin
						pc_q <= npc;
						if (cur_q.bad) begin
							st_q <= ST_INV;
						end else begin
							case (cur_q.op)
								OP_LIT: begin
									if (sp1_ok) sp_q <= sp_q + SP_W'(1);
									else st_q <= ST_RANGE;
								end
								OP_INC: begin
									if (inc_ok) sp_q <= inc_b[SP_W-1:0];
									else st_q <= ST_RANGE;
								end
								OP_JMP: pc_q <= PC_W'(cur_q.m);
								OP_JPC: begin
									if (sp_nz) state_q <= S_JPC;
									else st_q <= ST_RANGE;
								end
								OP_LOD, OP_STO, OP_CAL: begin
									base_q  <= bp_q;
									cnt_q   <= cur_q.level;
									state_q <= S_WALK;
								end
								OP_OPR: begin
									if (mop == OPR_RET) begin
										if (ret_ok) state_q <= S_RET1;
										else st_q <= ST_RANGE;
									end else if (mop == OPR_NEG || mop == OPR_ODD) begin
										state_q <= S_UNA;
									end else begin
										if (sp_nz) state_q <= S_BIN1;
										else st_q <= ST_RANGE;
									end
								end
								default: begin
									if (cur_q.m == SIO_PRINT) begin
										if (sp_nz) state_q <= S_PRT;
										else st_q <= ST_RANGE;
									end else if (cur_q.m == SIO_READ) begin
										if (sp1_ok) sp_q <= sp_q + SP_W'(1);
										else st_q <= ST_RANGE;
									end else begin
										halt_q <= 1'b1;
									end
								end
							endcase
						end
					end
				end
				S_PRT: begin
					pv_q    <= 1'b1;
					pval_q  <= rdata_q;
					sp_q    <= sp_q - SP_W'(1);
					state_q <= S_TOP;
				end
				S_JPC: begin
					state_q <= S_TOP;
					if (rdata_q == '0 && !cur_q.tgt_ok) begin
						st_q <= ST_INV;
					end else begin
						if (rdata_q == '0) pc_q <= PC_W'(cur_q.m);
						sp_q <= sp_q - SP_W'(1);
					end
				end
				S_WALK: begin
					if (cnt_q == 2'd0) begin
						state_q <= S_ADDR;
					end else if (base1_ok) begin
						state_q <= S_WALKD;
					end else begin
						st_q    <= ST_RANGE;
						state_q <= S_TOP;
					end
				end
				S_WALKD: begin
					if (rd_ok) begin
						base_q  <= rd_b[SP_W-1:0];
						cnt_q   <= cnt_q - 2'd1;
						state_q <= S_WALK;
					end else begin
						st_q    <= ST_RANGE;
						state_q <= S_TOP;
					end
				end
				S_ADDR: begin
					addr_q  <= addr_b[SP_W-1:0];
					state_q <= S_TOP;
					case (cur_q.op)
						OP_LOD: begin
							if (addr_ok && sp1_ok) state_q <= S_LODW;
							else st_q <= ST_RANGE;
						end
						OP_STO: begin
							if (addr_ok && sp_nz) state_q <= S_STOW;
							else st_q <= ST_RANGE;
						end
						default: begin
							cnt_q <= 2'd0;
							if (sp4_ok) state_q <= S_CALW;
							else st_q <= ST_RANGE;
						end
					endcase
				end
				S_LODW: begin
					sp_q    <= sp_q + SP_W'(1);
					state_q <= S_TOP;
				end
				S_STOW: begin
					sp_q    <= sp_q - SP_W'(1);
					state_q <= S_TOP;
				end
				S_CALW: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						bp_q    <= sp_q + SP_W'(1);
						pc_q    <= PC_W'(cur_q.m);
						state_q <= S_TOP;
					end
				end
				S_RET1: begin
					ra_q    <= rdata_q;
					state_q <= S_RET2;
				end
				S_RET2: begin
					state_q <= S_TOP;
					if (!ra_ok) begin
						st_q <= ST_INV;
					end else if (!rd_ok) begin
						st_q <= ST_RANGE;
					end else begin
						sp_q <= bp_q - SP_W'(1);
						bp_q <= rd_b[SP_W-1:0];
						pc_q <= ra_b[PC_W-1:0];
					end
				end
				S_UNA: state_q <= S_TOP;
				S_BIN1: begin
					b_q     <= rdata_q;
					state_q <= S_BIN2;
				end
				S_BIN2: begin
					if (divz) begin
						st_q    <= ST_DIVZ;
						state_q <= S_TOP;
					end else if (is_md) begin
						state_q <= S_MD;
					end else begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= S_TOP;
					end
				end
				S_MD: begin
					if (md_done) begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= S_TOP;
					end
				end
				S_TOP: state_q <= S_OUT;
				S_OUT: begin
					out_valid_q <= 1'b1;
					o_pc_q      <= 9'(pc_q);
					o_sp_q      <= 11'(sp_q);
					o_bp_q      <= 11'(bp_q);
					o_top_q     <= 32'(signed'(rdata_q));
					o_pv_q      <= pv_q;
					o_pval_q    <= 32'(signed'(pval_q));
					o_halt_q    <= halt_q;
					o_st_q      <= st_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.next_pc     = o_pc_q;
	assign out_ch.sp_after    = o_sp_q;
	assign out_ch.bp_after    = o_bp_q;
	assign out_ch.top_value   = o_top_q;
	assign out_ch.print_valid = o_pv_q;
	assign out_ch.print_value = o_pval_q;
	assign out_ch.halted      = o_halt_q;
	assign out_ch.status      = o_st_q;

`ifndef SYNTH
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt flag dropped");
	a_md_only_in_md: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == S_MD)) else $error("divider finished outside wait state");
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> !out_valid_q) else $error("result register overwritten");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == S_EXEC)) else $error("popped item not executed");
`endif
endmodule

@@ sv/pm0_stack_machine_execute.sv @@
// Top level of the P-machine execution block: instruction front end, queue,
// execution sequencer with stack memory. Depends on pm0_pkg, pm0_if, pm0_front, pm0_back.
//
//  Channel  Direction  Carries
//  in_ch    sink       op, level, m_field, in_value (one instruction per item)
//  out_ch   source     next_pc, sp_after, bp_after, top_value, print_valid,
//                      print_value, halted, status (one result per item)
//
// After reset the stack memory is cleared, one word a cycle; no item is accepted
// during that pass. In the sequencer, LIT, INC, JMP, SIO read and halt, items flagged
// by the front end and items that arrive once halted go straight to the result;
// print, JPC, negate and odd first read the top of stack; return and the other
// two-operand operations read two stack words; LOD, STO and CAL also walk the
// static links, one per level, and CAL writes a four-word frame. Multiply, divide
// and modulo run in the bit-serial unit after both operands are read.
// The sequencer starts an item only once the previous result has left the output
// register. The front queue holds two items, so input keeps flowing while the
// sequencer works or while a finished result waits, until the queue is full.
module pm0_stack_machine_execute #(
	parameter int STACK_DEPTH = 2048,
	parameter int CODE_DEPTH  = 512,
	parameter int MAX_LEVELS  = 3,
	parameter int WORD_BITS   = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	pm0_in_if.sink     in_ch,
	pm0_out_if.source  out_ch
);
	import pm0_pkg::*;

	// Queue head and handshake between the front end and the sequencer.
	entry_t head;
	logic   head_valid;
	logic   pop;
	logic   clearing;

	// The front end classifies each item so the sequencer sees operand faults
	// already flagged; only runtime checks remain for the back end.
	pm0_front #(
		.CODE_DEPTH (CODE_DEPTH),
		.MAX_LEVELS (MAX_LEVELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.clearing   (clearing),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The sequencer owns pc, sp, bp, the halt flag and the stack memory.
	pm0_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.CODE_DEPTH  (CODE_DEPTH),
		.WORD_BITS   (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.out_ch     (out_ch)
	);
endmodule

@@ dv/pm0_exec_checker.sv @@
// Result checker for the P-machine execution block: keeps its own copy of pc, sp, bp,
// the stack and the halt flag, predicts each result and compares it with the block.
// Depends on pm0_pkg and the pm0_in_if / pm0_out_if interfaces.
module pm0_exec_checker (
	input  logic clk,
	input  logic arst_n,
	pm0_in_if    in_ch,
	pm0_out_if   out_ch,
	output int   errors,
	output int   pending,
	output int   n_results,
	output int   n_faults,
	output int   n_prints
);
	timeunit 1ns;
	timeprecision 1ps;
	import pm0_pkg::*;

	localparam int STK_N  = 2048;
	localparam int CODE_N = 512;
	localparam int LVL_MAX = 3;

	typedef struct packed {
		logic [8:0]         pc;
		logic [10:0]        sp;
		logic [10:0]        bp;
		logic signed [31:0] top;
		logic               pvalid;
		logic signed [31:0] pval;
		logic               halted;
		logic [1:0]         status;
	} pm_result_t;

	int unsigned        pc_q, sp_q, bp_q;
	logic signed [31:0] stack_mem [STK_N];
	bit                 halt_q;
	pm_result_t         results_due [$];

	function automatic bit in_stk(longint a);
		return a >= 0 && a < STK_N;
	endfunction

	function automatic bit in_code(longint a);
		return a >= 0 && a < CODE_N;
	endfunction

	// Follows the static links from bp, one per level.
	function automatic bit walk_links(int lv, output longint b);
		b = bp_q;
		for (int i = 0; i < lv; i++) begin
			if (!in_stk(b + 1))
				return 0;
			b = longint'(stack_mem[b + 1]);
			if (!in_stk(b))
				return 0;
		end
		return 1;
	endfunction

	function automatic logic [1:0] exec_instr(input logic [3:0] op, input int lv,
		input longint m, input longint iv, inout int npc,
		output logic pvalid, output logic signed [31:0] pval);
		longint base, addr, ra, dl, sa, sb, r;
		pvalid = 0;
		pval = '0;
		case (op)
			OP_LIT: begin
				if (!in_stk(sp_q + 1))
					return ST_RANGE;
				sp_q++;
				stack_mem[sp_q] = m[31:0];
				return ST_OK;
			end
			OP_OPR: begin
				if (m == OPR_RET) begin
					if (bp_q < 1 || !in_stk(bp_q + 3))
						return ST_RANGE;
					ra = longint'(stack_mem[bp_q + 3]);
					dl = longint'(stack_mem[bp_q + 2]);
					if (!in_code(ra))
						return ST_INV;
					if (!in_stk(dl))
						return ST_RANGE;
					sp_q = bp_q - 1;
					bp_q = dl;
					npc = ra;
					return ST_OK;
				end
				if (m == OPR_NEG) begin
					stack_mem[sp_q] = -stack_mem[sp_q];
					return ST_OK;
				end
				if (m == OPR_ODD) begin
					stack_mem[sp_q] = stack_mem[sp_q] & 32'sd1;
					return ST_OK;
				end
				if (m < 2 || m > 13)
					return ST_INV;
				if (sp_q < 1)
					return ST_RANGE;
				sa = longint'(stack_mem[sp_q - 1]);
				sb = longint'(stack_mem[sp_q]);
				if ((m == OPR_DIV || m == OPR_MOD) && sb == 0)
					return ST_DIVZ;
				case (m[3:0])
					OPR_ADD: r = sa + sb;
					OPR_SUB: r = sa - sb;
					OPR_MUL: r = sa * sb;
					OPR_DIV: r = (sb == -1) ? -sa : sa / sb;
					OPR_MOD: r = (sb == -1) ? 0 : sa % sb;
					OPR_EQL: r = sa == sb;
					OPR_NEQ: r = sa != sb;
					OPR_LSS: r = sa < sb;
					OPR_LEQ: r = sa <= sb;
					OPR_GTR: r = sa > sb;
					default: r = sa >= sb;
				endcase
				sp_q--;
				stack_mem[sp_q] = r[31:0];
				return ST_OK;
			end
			OP_LOD, OP_STO: begin
				if (lv > LVL_MAX)
					return ST_INV;
				if (!walk_links(lv, base))
					return ST_RANGE;
				addr = base + m;
				if (!in_stk(addr))
					return ST_RANGE;
				if (op == OP_LOD) begin
					if (!in_stk(sp_q + 1))
						return ST_RANGE;
					sp_q++;
					stack_mem[sp_q] = stack_mem[addr];
				end else begin
					if (sp_q < 1)
						return ST_RANGE;
					stack_mem[addr] = stack_mem[sp_q];
					sp_q--;
				end
				return ST_OK;
			end
			OP_CAL: begin
				if (lv > LVL_MAX || !in_code(m))
					return ST_INV;
				if (!walk_links(lv, base))
					return ST_RANGE;
				if (!in_stk(sp_q + 4))
					return ST_RANGE;
				// Frame: return value, static link, dynamic link, return address.
				stack_mem[sp_q + 1] = '0;
				stack_mem[sp_q + 2] = base[31:0];
				stack_mem[sp_q + 3] = bp_q;
				stack_mem[sp_q + 4] = npc;
				bp_q = sp_q + 1;
				npc = m;
				return ST_OK;
			end
			OP_INC: begin
				addr = sp_q + m;
				if (!in_stk(addr))
					return ST_RANGE;
				sp_q = addr;
				return ST_OK;
			end
			OP_JMP: begin
				if (!in_code(m))
					return ST_INV;
				npc = m;
				return ST_OK;
			end
			OP_JPC: begin
				if (sp_q < 1)
					return ST_RANGE;
				if (stack_mem[sp_q] == 0) begin
					if (!in_code(m))
						return ST_INV;
					npc = m;
				end
				sp_q--;
				return ST_OK;
			end
			OP_SIO: begin
				if (m == SIO_PRINT) begin
					if (sp_q < 1)
						return ST_RANGE;
					pvalid = 1;
					pval = stack_mem[sp_q];
					sp_q--;
					return ST_OK;
				end
				if (m == SIO_READ) begin
					if (!in_stk(sp_q + 1))
						return ST_RANGE;
					sp_q++;
					stack_mem[sp_q] = iv[31:0];
					return ST_OK;
				end
				if (m == SIO_HALT) begin
					halt_q = 1;
					return ST_OK;
				end
				return ST_INV;
			end
			default: return ST_INV;
		endcase
	endfunction

	task automatic predict_result(input logic [3:0] op, input logic [1:0] lv,
		input logic signed [31:0] m, input logic signed [31:0] iv);
		pm_result_t res;
		int npc;
		logic pv;
		logic signed [31:0] pval;
		logic [1:0] st;
		pv = 0;
		pval = '0;
		st = ST_OK;
		if (!halt_q) begin
			npc = (pc_q + 1) % CODE_N;
			st = exec_instr(op, lv, m, iv, npc, pv, pval);
			pc_q = npc;
		end
		res.pc = pc_q;
		res.sp = sp_q;
		res.bp = bp_q;
		res.top = stack_mem[sp_q];
		res.pvalid = pv;
		res.pval = pv ? pval : '0;
		res.halted = halt_q;
		res.status = st;
		results_due.push_back(res);
	endtask

	task automatic report(input string field, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	initial begin
		pc_q = 0;
		sp_q = 0;
		bp_q = 1;
		halt_q = 0;
		foreach (stack_mem[i])
			stack_mem[i] = '0;
		errors = 0;
		n_results = 0;
		n_faults = 0;
		n_prints = 0;
	end

	assign pending = results_due.size();

	always @(posedge clk) begin
		pm_result_t want;
		if (arst_n && in_ch.valid && in_ch.ready)
			predict_result(in_ch.op, in_ch.level, in_ch.m_field, in_ch.in_value);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result item arrived with none outstanding", $realtime);
				errors++;
			end else begin
				want = results_due.pop_front();
				n_results++;
				if (want.status != ST_OK)
					n_faults++;
				if (want.pvalid)
					n_prints++;
				if (out_ch.next_pc !== want.pc)
					report("next_pc", out_ch.next_pc, want.pc);
				if (out_ch.sp_after !== want.sp)
					report("sp_after", out_ch.sp_after, want.sp);
				if (out_ch.bp_after !== want.bp)
					report("bp_after", out_ch.bp_after, want.bp);
				if (out_ch.top_value !== want.top)
					report("top_value", out_ch.top_value, want.top);
				if (out_ch.print_valid !== want.pvalid)
					report("print_valid", out_ch.print_valid, want.pvalid);
				if (out_ch.print_value !== want.pval)
					report("print_value", out_ch.print_value, want.pval);
				if (out_ch.halted !== want.halted)
					report("halted", out_ch.halted, want.halted);
				if (out_ch.status !== want.status)
					report("status", out_ch.status, want.status);
			end
		end
	end

endmodule

@@ dv/tb_pm0_stack_machine_execute.sv @@
// Top of the P-machine execution testbench: clock, reset, instruction stimulus,
// result-side stalls and the verdict. Depends on pm0_pkg, pm0_if, the block and
// pm0_exec_checker.
module tb_pm0_stack_machine_execute;
	timeunit 1ns;
	timeprecision 1ps;
	import pm0_pkg::*;

	// The limit leaves room for every item even with the long result stall, plus
	// the clearing pass of the stack memory after reset.
	localparam int CYCLE_LIMIT = 900000;

	logic clk;
	logic arst_n;
	int   errors, pending, n_results, n_faults, n_prints;
	int   cycles;
	int   sent;

	// Idle control: no_idle disables random gaps on both sides, stall_go asks
	// the receiver for one long hold-off.
	bit no_idle;
	bit stall_go;

	pm0_in_if  in_ch ();
	pm0_out_if out_ch ();

	pm0_stack_machine_execute uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pm0_exec_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.errors    (errors),
		.pending   (pending),
		.n_results (n_results),
		.n_faults  (n_faults),
		.n_prints  (n_prints)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that hangs anywhere ends here as a failure.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("pm0_stack_machine_execute test failed");
				$finish;
			end
		end
	end

	// Result side: accepts at random, with one long hold-off when asked so that
	// the front queue fills and the block stops taking instructions.
	initial begin
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_go) begin
				stall_go = 0;
				for (int i = 0; i < 400; i++) begin
					out_ch.ready <= 0;
					@(posedge clk);
				end
			end
			out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 12);
		end
	end

	// Offers one instruction and holds it until the block takes it. Random
	// gaps, with valid low, come before the item, never while it is offered.
	task automatic send_instr(input logic [3:0] op, input logic [1:0] lv,
		input logic signed [31:0] m, input logic signed [31:0] iv);
		while (!no_idle && $urandom_range(0, 99) < 12) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid    <= 1;
		in_ch.op       <= op;
		in_ch.level    <= lv;
		in_ch.m_field  <= m;
		in_ch.in_value <= iv;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sent++;
	endtask

	// Random instruction mix. Pushes and pops are roughly balanced so the stack
	// stays in a useful range; calls and returns pair up often enough to build
	// real frames for the static-link walk. A small share is plain noise.
	task automatic send_random();
		int r;
		logic [3:0] op;
		logic [1:0] lv;
		logic signed [31:0] m, iv;
		r  = $urandom_range(0, 99);
		lv = $urandom_range(0, 3);
		iv = $urandom;
		if (r < 18) begin
			op = OP_LIT;
			m = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20) - 10;
		end else if (r < 23) begin
			op = OP_SIO;
			m = SIO_READ;
		end else if (r < 45) begin
			op = OP_OPR;
			m = $urandom_range(OPR_ADD, OPR_GEQ);
		end else if (r < 49) begin
			op = OP_OPR;
			m = $urandom_range(0, 1) ? OPR_NEG : OPR_ODD;
		end else if (r < 53) begin
			op = OP_OPR;
			m = OPR_RET;
		end else if (r < 70) begin
			op = (r < 62) ? OP_LOD : OP_STO;
			m = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 12);
		end else if (r < 74) begin
			op = OP_CAL;
			m = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 511);
		end else if (r < 80) begin
			op = OP_INC;
			m = $urandom_range(0, 9) - 6;
		end else if (r < 85) begin
			op = OP_JMP;
			m = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 511);
		end else if (r < 91) begin
			op = OP_JPC;
			m = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 511);
		end else if (r < 96) begin
			op = OP_SIO;
			m = SIO_PRINT;
		end else begin
			// Bad opcodes and bad sub-operations, with every bit of m at play.
			op = $urandom_range(0, 1) ? OP_SIO : ($urandom_range(0, 1) ? 4'd0
				: 4'($urandom_range(10, 15)));
			m = $urandom;
			if (m == SIO_HALT)
				m = 32'sd3;
		end
		send_instr(op, lv, m, iv);
	endtask

	initial begin
		sent = 0;
		no_idle = 0;
		stall_go = 0;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.op = '0;
		in_ch.level = '0;
		in_ch.m_field = '0;
		in_ch.in_value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// Directed part. A print on an empty stack is the first item, so the
		// pop-from-zero case is hit before anything is pushed.
		send_instr(OP_SIO, 0, SIO_PRINT, 0);
		send_instr(OP_LIT, 0, 32'sh7fffffff, 0);
		send_instr(OP_LIT, 0, 32'sd1, 0);
		send_instr(OP_OPR, 0, OPR_ADD, 0);                  // wraps to most negative
		send_instr(OP_SIO, 0, SIO_READ, 32'sh80000000);
		send_instr(OP_OPR, 0, OPR_NEG, 0);                  // negating min stays min
		send_instr(OP_LIT, 0, -32'sd1, 0);
		send_instr(OP_OPR, 0, OPR_DIV, 0);                  // min / -1
		send_instr(OP_LIT, 0, -32'sd7, 0);
		send_instr(OP_LIT, 0, 32'sd2, 0);
		send_instr(OP_OPR, 0, OPR_MOD, 0);                  // remainder takes dividend sign
		send_instr(OP_LIT, 0, 32'sd0, 0);
		send_instr(OP_OPR, 0, OPR_DIV, 0);                  // divide by zero
		send_instr(OP_OPR, 0, OPR_ODD, 0);
		send_instr(OP_CAL, 2, 32'sd511, 0);                 // call with static-link walk
		send_instr(OP_LOD, 3, 32'sd2, 0);
		send_instr(OP_STO, 1, 32'sh7fffffff, 0);            // address out of range
		send_instr(OP_OPR, 0, OPR_RET, 0);
		send_instr(OP_INC, 0, 32'sh80000000, 0);            // sp underflow
		send_instr(OP_JMP, 0, 32'sd512, 0);                 // target past code end
		send_instr(OP_JPC, 0, -32'sd1, 0);
		send_instr(OP_OPR, 0, 32'sd14, 0);                  // bad sub-operation
		send_instr(4'd0, 3, 32'sd0, 32'shffffffff);
		send_instr(4'd15, 0, 32'sd0, 0);
		send_instr(OP_SIO, 0, 32'sd3, 0);

		repeat (400) send_random();

		// Sender pause: let every outstanding result drain before going on.
		in_ch.valid <= 0;
		while (pending != 0)
			@(posedge clk);

		// Long hold-off on the result side while instructions keep coming.
		stall_go = 1;
		repeat (300) send_random();

		// A stretch with no idling on either side.
		no_idle = 1;
		repeat (300) send_random();
		no_idle = 0;

		repeat (620) send_random();

		// Halt, then a few instructions the block must ignore.
		send_instr(OP_SIO, 0, SIO_HALT, 0);
		repeat (4) send_random();
		in_ch.valid <= 0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d instructions; %0d results checked, %0d with a fault status,",
			sent, n_results, n_faults);
		$display("%0d prints, including halt, long output stall and drain phases.", n_prints);
		if (errors == 0) begin
			$display("pm0_stack_machine_execute test passed");
		end else begin
			$display("pm0_stack_machine_execute test failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/pm0_pkg.sv
sv/pm0_if.sv
sv/pm0_front.sv
sv/pm0_muldiv.sv
sv/pm0_back.sv
sv/pm0_stack_machine_execute.sv
dv/pm0_exec_checker.sv
dv/tb_pm0_stack_machine_execute.sv
